// File: rtl/arming_spool_landed_supervisor_core_macros.svh
// Assertion macros shared by the supervisor core.
`ifndef ARMING_SPOOL_LANDED_SUPERVISOR_CORE_MACROS_SVH
`define ARMING_SPOOL_LANDED_SUPERVISOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASLSUP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASLSUP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/aslsup_pkg.sv
package aslsup_pkg;

    localparam int TICK_BITS = 16;
    localparam int CMP_BITS  = (TICK_BITS > 16) ? TICK_BITS : 16;
    localparam int PROD_BITS = 16 + TICK_BITS;
    localparam int DIV_STEPS = PROD_BITS;
    localparam int STEP_BITS = $clog2(DIV_STEPS);

    localparam logic [TICK_BITS-1:0] CNT_MAX = '1;

    localparam logic signed [15:0] MODE_EDGE_NEG = -16'sd10813;
    localparam logic signed [15:0] MODE_EDGE_POS = 16'sd10813;

    localparam logic [2:0] CFG_TAKEOFF_THR_STAB = 3'd0;
    localparam logic [2:0] CFG_TAKEOFF_THR_HOLD = 3'd1;
    localparam logic [2:0] CFG_TAKEOFF_DEBOUNCE = 3'd2;
    localparam logic [2:0] CFG_SPOOL_TICKS      = 3'd3;
    localparam logic [2:0] CFG_LANDED_THRUST    = 3'd4;
    localparam logic [2:0] CFG_LANDED_SPEED     = 3'd5;
    localparam logic [2:0] CFG_LANDED_DEBOUNCE  = 3'd6;

    typedef enum logic [1:0] {
        PH_DISARMED = 2'd0,
        PH_IDLE     = 2'd1,
        PH_ACTIVE   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        MODE_STAB = 2'd0,
        MODE_ALT  = 2'd1,
        MODE_POS  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        CTL_IDLE  = 2'd0,
        CTL_MUL   = 2'd1,
        CTL_DIV   = 2'd2,
        CTL_WRITE = 2'd3
    } ctl_state_t;

    typedef struct packed {
        logic accept;
        logic mul_load;
        logic div_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic spool_now;
        logic out_free;
    } dp_status_t;

    // Saturating increment of a tick counter.
    function automatic logic [TICK_BITS-1:0] bump(input logic [TICK_BITS-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

endpackage

// File: rtl/aslsup_ctrl.sv
module aslsup_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  aslsup_pkg::dp_status_t  status,
    output aslsup_pkg::dp_cmd_t     cmd
);

    aslsup_pkg::ctl_state_t           state_reg, state_next;
    logic [aslsup_pkg::STEP_BITS-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= aslsup_pkg::CTL_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            aslsup_pkg::CTL_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.spool_now ? aslsup_pkg::CTL_MUL
                                                  : aslsup_pkg::CTL_WRITE;
                end
            end
            aslsup_pkg::CTL_MUL:
            begin
                cmd.mul_load = 1'b1;
                step_next    = aslsup_pkg::STEP_BITS'(aslsup_pkg::DIV_STEPS - 1);
                state_next   = aslsup_pkg::CTL_DIV;
            end
            aslsup_pkg::CTL_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == '0)
                begin
                    state_next = aslsup_pkg::CTL_WRITE;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            aslsup_pkg::CTL_WRITE:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = aslsup_pkg::CTL_IDLE;
                end
            end
            default:
            begin
                state_next = aslsup_pkg::CTL_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != aslsup_pkg::CTL_IDLE);

endmodule

// File: rtl/aslsup_dp.sv
module aslsup_dp (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [2:0]              cfg_index,
    input  logic [15:0]             cfg_data,
    input  logic                    armed,
    input  logic signed [15:0]      throttle_stick,
    input  logic signed [15:0]      mode_stick,
    input  logic signed [15:0]      cascade_thrust,
    input  logic signed [15:0]      vertical_speed,
    input  aslsup_pkg::dp_cmd_t     cmd,
    output aslsup_pkg::dp_status_t  status,
    input  logic                    out_stall,
    output logic                    out_valid,
    output logic [1:0]              phase,
    output logic [1:0]              fly_mode,
    output logic signed [15:0]      thrust_cmd,
    output logic                    cascade_enable,
    output logic                    controllers_reset,
    output logic                    spooling
);

    localparam int TB = aslsup_pkg::TICK_BITS;
    localparam int CB = aslsup_pkg::CMP_BITS;
    localparam int PB = aslsup_pkg::PROD_BITS;

    // configuration
    logic [14:0] thr_stab_reg, thr_hold_reg, land_thr_reg, land_spd_reg;
    logic [15:0] to_deb_reg, spool_tot_reg, land_deb_reg;

    // supervisor state
    aslsup_pkg::phase_t phase_reg, phase_next;
    aslsup_pkg::mode_t  mode_reg, mode_next;
    logic [TB-1:0]      takeoff_reg, takeoff_next;
    logic [TB-1:0]      landed_reg, landed_next;
    logic [TB-1:0]      spool_reg, spool_next;

    // tick evaluation results
    logic               rst_next, en_next, sp_next;
    logic [TB-1:0]      sc_mul_next;

    // staged result and ramp datapath
    aslsup_pkg::phase_t st_phase_reg;
    aslsup_pkg::mode_t  st_mode_reg;
    logic signed [15:0] st_thrust_reg;
    logic               st_en_reg, st_rst_reg, st_sp_reg, st_neg_reg;
    logic [15:0]        mag_reg;
    logic [TB-1:0]      sc_mul_reg;
    logic [PB-1:0]      dvd_reg;
    logic [15:0]        rem_reg;
    logic [15:0]        quo_reg;

    logic [16:0]        rem_shift;
    logic [17:0]        rem_diff;
    logic               rem_ge;
    logic [15:0]        ramp_thrust;

    // output register
    logic               out_valid_reg;
    aslsup_pkg::phase_t out_phase_reg;
    aslsup_pkg::mode_t  out_mode_reg;
    logic signed [15:0] out_thrust_reg;
    logic               out_en_reg, out_rst_reg, out_sp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_stab_reg  <= 15'd6554;
            thr_hold_reg  <= 15'd16384;
            to_deb_reg    <= 16'd50;
            spool_tot_reg <= 16'd500;
            land_thr_reg  <= 15'd3277;
            land_spd_reg  <= 15'd26;
            land_deb_reg  <= 16'd200;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                aslsup_pkg::CFG_TAKEOFF_THR_STAB: thr_stab_reg  <= cfg_data[14:0];
                aslsup_pkg::CFG_TAKEOFF_THR_HOLD: thr_hold_reg  <= cfg_data[14:0];
                aslsup_pkg::CFG_TAKEOFF_DEBOUNCE: to_deb_reg    <= cfg_data;
                aslsup_pkg::CFG_SPOOL_TICKS:      spool_tot_reg <= cfg_data;
                aslsup_pkg::CFG_LANDED_THRUST:    land_thr_reg  <= cfg_data[14:0];
                aslsup_pkg::CFG_LANDED_SPEED:     land_spd_reg  <= cfg_data[14:0];
                aslsup_pkg::CFG_LANDED_DEBOUNCE:  land_deb_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Evaluate one tick from the ports and the current state.
    always_comb
    begin
        logic [14:0]        lvl;
        logic signed [16:0] thr_x, cthr_x, vz_x, avz;
        logic               looks_landed;

        thr_x  = {throttle_stick[15], throttle_stick};
        cthr_x = {cascade_thrust[15], cascade_thrust};
        vz_x   = {vertical_speed[15], vertical_speed};
        avz    = vertical_speed[15] ? -vz_x : vz_x;

        phase_next   = phase_reg;
        takeoff_next = takeoff_reg;
        landed_next  = landed_reg;
        spool_next   = spool_reg;
        rst_next     = 1'b0;
        en_next      = 1'b0;
        sp_next      = 1'b0;
        sc_mul_next  = spool_reg;
        looks_landed = 1'b0;

        if (mode_stick < aslsup_pkg::MODE_EDGE_NEG)
        begin
            mode_next = aslsup_pkg::MODE_STAB;
        end
        else if (mode_stick > aslsup_pkg::MODE_EDGE_POS)
        begin
            mode_next = aslsup_pkg::MODE_POS;
        end
        else
        begin
            mode_next = aslsup_pkg::MODE_ALT;
        end
        if (mode_next != mode_reg)
        begin
            rst_next = 1'b1;
        end
        lvl = (mode_next == aslsup_pkg::MODE_STAB) ? thr_stab_reg : thr_hold_reg;

        if (!armed)
        begin
            if (phase_reg != aslsup_pkg::PH_DISARMED)
            begin
                rst_next = 1'b1;
            end
            phase_next   = aslsup_pkg::PH_DISARMED;
            takeoff_next = '0;
            landed_next  = '0;
            spool_next   = '0;
        end
        else
        begin
            if (phase_reg != aslsup_pkg::PH_IDLE && phase_reg != aslsup_pkg::PH_ACTIVE)
            begin
                phase_next   = aslsup_pkg::PH_IDLE;
                rst_next     = 1'b1;
                takeoff_next = '0;
            end
            if (phase_next == aslsup_pkg::PH_IDLE)
            begin
                if (thr_x > $signed({2'b00, lvl}))
                begin
                    takeoff_next = aslsup_pkg::bump(takeoff_next);
                    if (CB'(takeoff_next) >= CB'(to_deb_reg))
                    begin
                        phase_next = aslsup_pkg::PH_ACTIVE;
                        spool_next = '0;
                    end
                end
                else
                begin
                    takeoff_next = '0;
                end
            end
            if (phase_next == aslsup_pkg::PH_IDLE)
            begin
                rst_next = 1'b1;
            end
            else
            begin
                en_next     = 1'b1;
                sc_mul_next = spool_next;
                sp_next     = CB'(spool_next) < CB'(spool_tot_reg);
                if (sp_next)
                begin
                    spool_next = aslsup_pkg::bump(spool_next);
                end
                looks_landed = !sp_next
                            && (cthr_x < $signed({2'b00, land_thr_reg}))
                            && (avz < $signed({2'b00, land_spd_reg}));
                if (looks_landed)
                begin
                    landed_next = aslsup_pkg::bump(landed_next);
                    if (CB'(landed_next) >= CB'(land_deb_reg))
                    begin
                        phase_next   = aslsup_pkg::PH_IDLE;
                        takeoff_next = '0;
                    end
                end
                else
                begin
                    landed_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= aslsup_pkg::PH_DISARMED;
            mode_reg    <= aslsup_pkg::MODE_STAB;
            takeoff_reg <= '0;
            landed_reg  <= '0;
            spool_reg   <= '0;
        end
        else if (cmd.accept)
        begin
            phase_reg   <= phase_next;
            mode_reg    <= mode_next;
            takeoff_reg <= takeoff_next;
            landed_reg  <= landed_next;
            spool_reg   <= spool_next;
        end
    end

    assign status.spool_now = sp_next;

    // restoring divide step, one quotient bit per cycle
    assign rem_shift = {rem_reg, dvd_reg[PB-1]};
    assign rem_diff  = {1'b0, rem_shift} - {2'b00, spool_tot_reg};
    assign rem_ge    = !rem_diff[17];

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            st_phase_reg  <= phase_next;
            st_mode_reg   <= mode_next;
            st_en_reg     <= en_next;
            st_rst_reg    <= rst_next;
            st_sp_reg     <= sp_next;
            st_thrust_reg <= en_next ? cascade_thrust : 16'sd0;
            st_neg_reg    <= cascade_thrust[15];
            mag_reg       <= cascade_thrust[15] ? 16'(-cascade_thrust) : cascade_thrust;
            sc_mul_reg    <= sc_mul_next;
        end
        if (cmd.mul_load)
        begin
            dvd_reg <= PB'(mag_reg) * PB'(sc_mul_reg);
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[PB-2:0], 1'b0};
            rem_reg <= rem_ge ? rem_diff[15:0] : rem_shift[15:0];
            quo_reg <= {quo_reg[14:0], rem_ge};
        end
    end

    assign ramp_thrust = st_neg_reg ? 16'(-quo_reg) : quo_reg;

    assign status.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_phase_reg  <= st_phase_reg;
            out_mode_reg   <= st_mode_reg;
            out_thrust_reg <= st_sp_reg ? $signed(ramp_thrust) : st_thrust_reg;
            out_en_reg     <= st_en_reg;
            out_rst_reg    <= st_rst_reg;
            out_sp_reg     <= st_sp_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign phase             = out_phase_reg;
    assign fly_mode          = out_mode_reg;
    assign thrust_cmd        = out_thrust_reg;
    assign cascade_enable    = out_en_reg;
    assign controllers_reset = out_rst_reg;
    assign spooling          = out_sp_reg;

endmodule

// File: rtl/arming_spool_landed_supervisor_core.sv
// Arming, spool-up and landed supervisor, one transaction per control tick.
// Input channel (in_valid/in_stall) carries the arm switch, throttle and mode
// sticks, cascade thrust and vertical speed. Output channel (out_valid/
// out_stall) returns phase, flight mode, gated thrust and the enable, reset
// and spooling flags. The write port (cfg_write/cfg_index/cfg_data) sets the
// seven thresholds; write only while no transaction is in flight.
// A tick without ramping goes from accept through the write state to
// out_valid; a ramp tick runs one multiply, then the serial divider at one
// quotient bit per cycle, then the output load once the output register is
// free. A new transaction is taken only after the current one is written to
// the output register, so the serial divider of the thrust ramp sets the pace.
// The output register decouples the sides: a new input is accepted while a
// result waits; a finished result holds in staging while out_stall is high.
// Reset restores the default thresholds, clears phase to disarmed, mode to
// stabilize and all tick counters to zero.
`include "arming_spool_landed_supervisor_core_macros.svh"

module arming_spool_landed_supervisor_core (
    input  logic               clk,
    input  logic               rst_n,
    // configuration write port
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               armed,
    input  logic signed [15:0] throttle_stick,
    input  logic signed [15:0] mode_stick,
    input  logic signed [15:0] cascade_thrust,
    input  logic signed [15:0] vertical_speed,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         phase,
    output logic [1:0]         fly_mode,
    output logic signed [15:0] thrust_cmd,
    output logic               cascade_enable,
    output logic               controllers_reset,
    output logic               spooling
);

    aslsup_pkg::dp_cmd_t    cmd;
    aslsup_pkg::dp_status_t status;

    // Sequence accept, multiply, divide and output load.
    aslsup_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold the supervisor state, evaluate ticks and run the thrust ramp.
    aslsup_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .armed             (armed),
        .throttle_stick    (throttle_stick),
        .mode_stick        (mode_stick),
        .cascade_thrust    (cascade_thrust),
        .vertical_speed    (vertical_speed),
        .cmd               (cmd),
        .status            (status),
        .out_stall         (out_stall),
        .out_valid         (out_valid),
        .phase             (phase),
        .fly_mode          (fly_mode),
        .thrust_cmd        (thrust_cmd),
        .cascade_enable    (cascade_enable),
        .controllers_reset (controllers_reset),
        .spooling          (spooling)
    );

    // Once a transaction is taken the block is busy on the next cycle.
    `ASLSUP_ASSERT_NEXT(a_busy_after_accept, cmd.accept, in_stall, "accept did not go busy")
    // Thrust passes only on the active path.
    `ASLSUP_ASSERT_NOW(a_thrust_gated, out_valid && !cascade_enable, thrust_cmd == 16'sd0,
        "thrust leaked while disabled")
    // The ramp runs only with the cascade enabled.
    `ASLSUP_ASSERT_NOW(a_spool_enabled, out_valid && spooling, cascade_enable,
        "spooling without enable")
    // A disarmed result never enables the cascade.
    `ASLSUP_ASSERT_NOW(a_disarmed_quiet,
        out_valid && (phase == aslsup_pkg::PH_DISARMED), !cascade_enable,
        "cascade enabled while disarmed")

endmodule
